// ===== rtl/lvt_pkg.sv =====
// ----------------------------------------------------------------------------
// lvt_pkg: shared types and constants for the LRU victim tracker
// Transaction payloads, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package lvt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 16;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);

    // operation codes carried in req_t.kind
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_VICTIM = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;

    // status codes carried in rsp_t.status
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] victim_key;
        logic [4:0]       entry_count;
    } rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             en;
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic             full;
    } cell_bcast_t;

endpackage

// ===== rtl/lvt_cell.sv =====
// ----------------------------------------------------------------------------
// lvt_cell: one recency slot
// Holds a key and valid mark; shifts from either neighbor on insert/erase.
// ----------------------------------------------------------------------------
module lvt_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lvt_pkg::cell_bcast_t        bcast,
    input  logic [lvt_pkg::KEY_W-1:0]   left_key,
    input  logic                        left_valid,
    input  logic [lvt_pkg::KEY_W-1:0]   right_key,
    input  logic                        right_valid,
    input  logic                        match_in,
    output logic                        match_out,
    output logic [lvt_pkg::KEY_W-1:0]   key,
    output logic                        valid,
    output logic [lvt_pkg::KEY_W-1:0]   victim_key
);

    logic [lvt_pkg::KEY_W-1:0] key_reg;
    logic [lvt_pkg::KEY_W-1:0] key_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      my_match;

    assign my_match   = valid_reg && (key_reg == bcast.key);
    assign match_out  = match_in | my_match;
    assign key        = key_reg;
    assign valid      = valid_reg;
    // last valid slot is the least recent one
    assign victim_key = (valid_reg && !right_valid) ? key_reg : '0;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (bcast.en)
        begin
            case (bcast.kind)
                lvt_pkg::OP_INSERT:
                begin
                    // slots up to and including the hit (or all on a miss when not full) move older
                    if ((bcast.hit || !bcast.full) && !match_in)
                    begin
                        key_next   = left_key;
                        valid_next = left_valid;
                    end
                end
                lvt_pkg::OP_VICTIM:
                begin
                    if (valid_reg && !right_valid)
                        valid_next = 1'b0;
                end
                lvt_pkg::OP_ERASE:
                begin
                    if (bcast.hit && match_out)
                    begin
                        key_next   = right_key;
                        valid_next = right_valid;
                    end
                end
                default:
                begin
                    key_next   = key_reg;
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/lru_victim_tracker_core.sv =====
// ----------------------------------------------------------------------------
// lru_victim_tracker_core: least-recently-used replacer over a chain of cells
// Insert/touch, take victim and erase, one transaction per cycle while out_ready is high.
// ----------------------------------------------------------------------------
// The result is registered at the edge that accepts the request.
// Throughput: 1 transaction per cycle while out_ready is high; the key compare runs in every cell
//   at once and the hit flag ripples down the cell chain, which sets the cycle time.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n, async, active low) clears all valid marks, the count and the
//   result valid flag; slot keys and result data are left as they are.
// ----------------------------------------------------------------------------
module lru_victim_tracker_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lvt_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lvt_pkg::rsp_t out_data
);

    localparam int CAP = lvt_pkg::CAPACITY;
    localparam int KW  = lvt_pkg::KEY_W;
    localparam int CW  = lvt_pkg::CNT_W;

    // Cell i holds the i-th most recent key; valid cells are always 0..count-1.
    logic [KW-1:0]         cell_key    [CAP];
    logic                  cell_valid  [CAP];
    logic [KW-1:0]         cell_victim [CAP];
    logic [CAP:0]          match_chain;

    logic                  fire;
    logic [KW-1:0]         req_key;
    logic                  hit;
    logic                  full;
    lvt_pkg::cell_bcast_t  bcast;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lvt_pkg::rsp_t         out_reg;
    lvt_pkg::rsp_t         out_next;

    logic [KW-1:0]         victim_any;
    logic [1:0]            status;

    assign fire     = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign req_key  = in_data.key & lvt_pkg::KEY_MASK;

    assign match_chain[0] = 1'b0;
    assign hit  = match_chain[CAP];
    assign full = (count_reg == CW'(CAP));

    assign bcast.en   = fire;
    assign bcast.kind = in_data.kind;
    assign bcast.key  = req_key;
    assign bcast.hit  = hit;
    assign bcast.full = full;

    // ------------------------------------------------------------------
    // Cell chain: cell 0 takes the new key from the left end, the far end
    // feeds an empty slot in from the right.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [KW-1:0] l_key;
        logic          l_valid;
        logic [KW-1:0] r_key;
        logic          r_valid;

        if (i == 0)
        begin : g_head
            assign l_key   = req_key;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_key   = cell_key[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == CAP - 1)
        begin : g_tail
            assign r_key   = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_key   = cell_key[i+1];
            assign r_valid = cell_valid[i+1];
        end

        lvt_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .bcast       (bcast),
            .left_key    (l_key),
            .left_valid  (l_valid),
            .right_key   (r_key),
            .right_valid (r_valid),
            .match_in    (match_chain[i]),
            .match_out   (match_chain[i+1]),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .victim_key  (cell_victim[i])
        );
    end

    // At most one cell reports a victim key (the last valid one).
    always_comb
    begin
        victim_any = '0;
        for (int i = 0; i < CAP; i++)
            victim_any = victim_any | cell_victim[i];
    end

    // ------------------------------------------------------------------
    // Count update and status
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        status     = lvt_pkg::ST_NONE;
        case (in_data.kind)
            lvt_pkg::OP_INSERT:
            begin
                if (hit)
                    status = lvt_pkg::ST_DONE;
                else if (full)
                    status = lvt_pkg::ST_FULL;
                else
                begin
                    status     = lvt_pkg::ST_DONE;
                    count_next = count_reg + CW'(1);
                end
            end
            lvt_pkg::OP_VICTIM:
            begin
                if (count_reg != '0)
                begin
                    status     = lvt_pkg::ST_DONE;
                    count_next = count_reg - CW'(1);
                end
            end
            lvt_pkg::OP_ERASE:
            begin
                if (hit)
                begin
                    status     = lvt_pkg::ST_DONE;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status     = lvt_pkg::ST_NONE;
                count_next = count_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = status;
            out_next.victim_key  = ((in_data.kind == lvt_pkg::OP_VICTIM) &&
                                    (status == lvt_pkg::ST_DONE)) ? victim_any : '0;
            out_next.entry_count = 5'(count_next);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= fire ? count_next : count_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/lvt_checker.sv =====
// ----------------------------------------------------------------------------
// lvt_checker: port-level checks for the LRU victim tracker
// Result consistency and output hold under back-pressure.
// ----------------------------------------------------------------------------
module lvt_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          out_valid,
    input  logic          out_ready,
    input  lvt_pkg::rsp_t out_data
);

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.entry_count <= lvt_pkg::CAPACITY))
        else $error("entry_count above capacity");

    // a refused insert only happens on a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == lvt_pkg::ST_FULL)) |->
        (out_data.entry_count == lvt_pkg::CAPACITY))
        else $error("full status with table not full");

    // victim key is zero unless the transaction succeeded
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != lvt_pkg::ST_DONE)) |->
        (out_data.victim_key == '0))
        else $error("victim key on failed transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

endmodule

bind lru_victim_tracker_core lvt_checker u_lvt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_victim_tracker_core
// Drives insert/touch, victim and erase transactions with random gaps and
// output stalls. A recency list kept in the bench predicts every response,
// and each response is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    // kind 3 has no operation behind it; the core must answer "none"
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int TAIL_CYCLES = 4;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    lvt_pkg::req_t in_data;
    logic          out_valid;
    logic          out_ready;
    lvt_pkg::rsp_t out_data;

    lru_victim_tracker_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Clock, 2 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Recency list: entry 0 is the most recently used key, entries
    // 0 .. recency_count-1 are the tracked ones.
    logic [lvt_pkg::KEY_W-1:0] recency_keys [lvt_pkg::CAPACITY];
    int unsigned               recency_count;

    lvt_pkg::rsp_t             pending_rsp_q [$];   // responses owed, oldest first
    logic [lvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE]; // small key set so hits happen
    bit                        idle_on;             // random gaps and stalls enabled
    int                        errors;
    int                        cycles;

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the recency list, return the response.
    // ------------------------------------------------------------------------
    function automatic lvt_pkg::rsp_t lru_apply(input lvt_pkg::req_t req);
        lvt_pkg::rsp_t             rsp;
        logic [lvt_pkg::KEY_W-1:0] k;
        int                        hit;
        int                        upto;

        k               = req.key & lvt_pkg::KEY_MASK;
        rsp.status      = lvt_pkg::ST_NONE;
        rsp.victim_key  = '0;
        hit             = -1;

        for (int i = int'(recency_count) - 1; i >= 0; i--)
        begin
            if (recency_keys[i] == k)
                hit = i;
        end

        case (req.kind)
            lvt_pkg::OP_INSERT:
            begin
                // touch moves the key to the front; a new key needs a free slot
                if (hit >= 0 || recency_count < lvt_pkg::CAPACITY)
                begin
                    upto = (hit >= 0) ? hit : int'(recency_count);
                    for (int i = upto; i > 0; i--)
                        recency_keys[i] = recency_keys[i-1];
                    recency_keys[0] = k;
                    if (hit < 0)
                        recency_count++;
                    rsp.status = lvt_pkg::ST_DONE;
                end
                else
                    rsp.status = lvt_pkg::ST_FULL;
            end
            lvt_pkg::OP_VICTIM:
            begin
                if (recency_count > 0)
                begin
                    rsp.victim_key = recency_keys[recency_count-1];
                    recency_count--;
                    rsp.status = lvt_pkg::ST_DONE;
                end
            end
            lvt_pkg::OP_ERASE:
            begin
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < int'(recency_count); i++)
                        recency_keys[i] = recency_keys[i+1];
                    recency_count--;
                    rsp.status = lvt_pkg::ST_DONE;
                end
            end
            default:
            begin
                // unused kind: no change, status none
            end
        endcase

        rsp.entry_count = 5'(recency_count);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. in_valid is left high after a transaction is accepted so
    // that back-to-back requests never lower and raise it in one time step;
    // it is dropped before a random gap, and settle() drops it before its wait.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [1:0] kind, input logic [lvt_pkg::KEY_W-1:0] key);
        lvt_pkg::req_t req;

        req.kind = kind;
        req.key  = key;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        // values read here are the ones present just before the edge
        do
            @(posedge clk);
        while (!in_ready);
        pending_rsp_q.push_back(lru_apply(req));
    endtask

    // Wait until every owed response has come back, plus the pipeline tail.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [lvt_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return lvt_pkg::KEY_W'($urandom);
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Weighted choice: 3% unused kind, then insert and victim, the rest erase.
    task automatic send_random(input int insert_pct, input int victim_pct);
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 3)
            send_op(OP_UNUSED, lvt_pkg::KEY_W'($urandom));
        else if (roll < 3 + insert_pct)
            send_op(lvt_pkg::OP_INSERT, pick_key());
        else if (roll < 3 + insert_pct + victim_pct)
            send_op(lvt_pkg::OP_VICTIM, lvt_pkg::KEY_W'($urandom));
        else
            send_op(lvt_pkg::OP_ERASE, pick_key());
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts on out_ready
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Response checker: every accepted response against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lvt_pkg::rsp_t exp_rsp;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected response: status %0d victim_key %h entry_count %0d",
                       out_data.status, out_data.victim_key, out_data.entry_count);
                errors++;
            end
            else
            begin
                exp_rsp = pending_rsp_q.pop_front();
                if (out_data.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, out_data.status);
                    errors++;
                end
                if (out_data.victim_key !== exp_rsp.victim_key)
                begin
                    $error("victim_key: expected %h, got %h",
                           exp_rsp.victim_key, out_data.victim_key);
                    errors++;
                end
                if (out_data.entry_count !== exp_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_rsp.entry_count, out_data.entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases from an empty table through a full one.
    task automatic test_directed();
        send_op(lvt_pkg::OP_VICTIM, 16'h0000);  // victim on empty table
        send_op(lvt_pkg::OP_ERASE, 16'h1234);   // erase of absent key
        send_op(OP_UNUSED, 16'h0000);           // unused kind on empty table
        send_op(lvt_pkg::OP_INSERT, 16'h0000);  // lowest key
        send_op(lvt_pkg::OP_INSERT, 16'hFFFF);  // highest key
        send_op(lvt_pkg::OP_INSERT, 16'h0000);  // touch of present key
        for (int i = 0; i < lvt_pkg::CAPACITY - 2; i++)
            send_op(lvt_pkg::OP_INSERT, 16'h0100 + lvt_pkg::KEY_W'(i));
        send_op(lvt_pkg::OP_INSERT, 16'hBEEF);  // new key into full table
        send_op(lvt_pkg::OP_INSERT, 16'hFFFF);  // touch while full
        send_op(lvt_pkg::OP_VICTIM, 16'hFFFF);  // evict least recent
        send_op(lvt_pkg::OP_ERASE, 16'h0105);   // erase from the middle
        send_op(lvt_pkg::OP_ERASE, 16'h0105);   // same key again, now absent
        send_op(OP_UNUSED, 16'hFFFF);           // unused kind with a full key
        settle();
    endtask

    // Alternate fill-heavy and drain-heavy bursts so the table keeps crossing
    // both the empty and the full boundary.
    task automatic test_fill_drain();
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = lvt_pkg::KEY_W'($urandom);
        for (int round = 0; round < 4; round++)
        begin
            repeat (60) send_random(75, 10);
            repeat (50) send_random(15, 45);
        end
        settle();
    endtask

    // Balanced mix; gaps and stalls switched on and off in stretches.
    task automatic test_random_mix();
        for (int seg = 0; seg < 4; seg++)
        begin
            idle_on = (seg % 2 == 0);
            repeat (40) send_random(45, 25);
        end
        idle_on = 1'b1;
        settle();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (50) send_random(70, 10);
        repeat (50) send_random(40, 30);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors        = 0;
        cycles        = 0;
        idle_on       = 1'b1;
        recency_count = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_drain();
        test_random_mix();
        test_full_rate();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
